/* rtl/fsfe_pkg.sv */
// ----------------------------------------------------------------------------
// fsfe_pkg: shared types and coefficient table
// Element kinds and the shape function coefficients (times 4).
// ----------------------------------------------------------------------------
package fsfe_pkg;

  typedef enum logic [1:0] {
    KIND_TRI3  = 2'd0,
    KIND_QUAD4 = 2'd1,
    KIND_QUAD8 = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  // coefficients over monomials 1,s,t,ss,st,tt,sst,stt
  typedef logic signed [3:0] coef_t;
  typedef coef_t coef_row_t [8];

  // q: 0 value, 1 d/ds, 2 d/dt
  function automatic coef_row_t coef_row(input logic [1:0] kind, input logic [2:0] node,
                                         input logic [1:0] q);
    coef_row_t r;
    logic [7:0] sel;
    for (int i = 0; i < 8; i++) r[i] = 4'sd0;
    sel = {kind, node, q};
    case (sel)
      {2'd0,3'd0,2'd0}: begin r[0]=4; r[1]=-4; r[2]=-4; end
      {2'd0,3'd0,2'd1}: begin r[0]=-4; end
      {2'd0,3'd0,2'd2}: begin r[0]=-4; end
      {2'd0,3'd1,2'd0}: begin r[1]=4; end
      {2'd0,3'd1,2'd1}: begin r[0]=4; end
      {2'd0,3'd2,2'd0}: begin r[2]=4; end
      {2'd0,3'd2,2'd2}: begin r[0]=4; end
      {2'd1,3'd0,2'd0}: begin r[0]=1; r[1]=-1; r[2]=-1; r[4]=1; end
      {2'd1,3'd0,2'd1}: begin r[0]=-1; r[2]=1; end
      {2'd1,3'd0,2'd2}: begin r[0]=-1; r[1]=1; end
      {2'd1,3'd1,2'd0}: begin r[0]=1; r[1]=1; r[2]=-1; r[4]=-1; end
      {2'd1,3'd1,2'd1}: begin r[0]=1; r[2]=-1; end
      {2'd1,3'd1,2'd2}: begin r[0]=-1; r[1]=-1; end
      {2'd1,3'd2,2'd0}: begin r[0]=1; r[1]=1; r[2]=1; r[4]=1; end
      {2'd1,3'd2,2'd1}: begin r[0]=1; r[2]=1; end
      {2'd1,3'd2,2'd2}: begin r[0]=1; r[1]=1; end
      {2'd1,3'd3,2'd0}: begin r[0]=1; r[1]=-1; r[2]=1; r[4]=-1; end
      {2'd1,3'd3,2'd1}: begin r[0]=-1; r[2]=-1; end
      {2'd1,3'd3,2'd2}: begin r[0]=1; r[1]=-1; end
      {2'd2,3'd0,2'd0}: begin r[0]=-1; r[3]=1; r[4]=1; r[5]=1; r[6]=-1; r[7]=-1; end
      {2'd2,3'd0,2'd1}: begin r[1]=2; r[2]=1; r[4]=-2; r[5]=-1; end
      {2'd2,3'd0,2'd2}: begin r[1]=1; r[2]=2; r[3]=-1; r[4]=-2; end
      {2'd2,3'd1,2'd0}: begin r[0]=2; r[2]=-2; r[3]=-2; r[6]=2; end
      {2'd2,3'd1,2'd1}: begin r[1]=-4; r[4]=4; end
      {2'd2,3'd1,2'd2}: begin r[0]=-2; r[3]=2; end
      {2'd2,3'd2,2'd0}: begin r[0]=-1; r[3]=1; r[4]=-1; r[5]=1; r[6]=-1; r[7]=1; end
      {2'd2,3'd2,2'd1}: begin r[1]=2; r[2]=-1; r[4]=-2; r[5]=1; end
      {2'd2,3'd2,2'd2}: begin r[1]=-1; r[2]=2; r[3]=-1; r[4]=2; end
      {2'd2,3'd3,2'd0}: begin r[0]=2; r[1]=2; r[5]=-2; r[7]=-2; end
      {2'd2,3'd3,2'd1}: begin r[0]=2; r[5]=-2; end
      {2'd2,3'd3,2'd2}: begin r[2]=-4; r[4]=-4; end
      {2'd2,3'd4,2'd0}: begin r[0]=-1; r[3]=1; r[4]=1; r[5]=1; r[6]=1; r[7]=1; end
      {2'd2,3'd4,2'd1}: begin r[1]=2; r[2]=1; r[4]=2; r[5]=1; end
      {2'd2,3'd4,2'd2}: begin r[1]=1; r[2]=2; r[3]=1; r[4]=2; end
      {2'd2,3'd5,2'd0}: begin r[0]=2; r[2]=2; r[3]=-2; r[6]=-2; end
      {2'd2,3'd5,2'd1}: begin r[1]=-4; r[4]=-4; end
      {2'd2,3'd5,2'd2}: begin r[0]=2; r[3]=-2; end
      {2'd2,3'd6,2'd0}: begin r[0]=-1; r[3]=1; r[4]=-1; r[5]=1; r[6]=1; r[7]=-1; end
      {2'd2,3'd6,2'd1}: begin r[1]=2; r[2]=-1; r[4]=2; r[5]=-1; end
      {2'd2,3'd6,2'd2}: begin r[1]=-1; r[2]=2; r[3]=1; r[4]=-2; end
      {2'd2,3'd7,2'd0}: begin r[0]=2; r[1]=-2; r[5]=-2; r[7]=2; end
      {2'd2,3'd7,2'd1}: begin r[0]=-2; r[5]=2; end
      {2'd2,3'd7,2'd2}: begin r[2]=-4; r[4]=4; end
      default: ;
    endcase
    return r;
  endfunction

endpackage

/* rtl/fem_shape_function_eval_core.sv */
// ----------------------------------------------------------------------------
// fem_shape_function_eval_core: tri3 / quad4 / quad8 shape functions
// Emits value, d/ds and d/dt for each node of one element at (s, t).
// ----------------------------------------------------------------------------
// One input transaction yields 3 (tri3), 4 (quad4) or 8 (quad8) result
// transactions in node order, the last one flagged by last_node; kind 3
// yields one zero result with kind_error set. A front stage sequences nodes,
// one per cycle while the output is not stalled, and takes the next input in
// the cycle it issues the last node of the current one; an unsupported kind
// issues a single node. Each node then flows through a four-stage pipeline:
// squares and cross product (ss, st, tt), cubic products (sst, stt),
// coefficient sums (coefficients are 0, +-1, +-2 or +-4, so each term is a
// shifted select), then the rounding add, the final shift and 18-bit
// saturation. Results leave at one per cycle while the output is not stalled.
// While a result waits under a stall the whole pipeline holds; bubbles keep
// moving.
module fem_shape_function_eval_core #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] s_coord,
  input  logic signed [15:0] t_coord,
  input  logic [1:0]         element_kind,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         node_index,
  output logic signed [17:0] shape_value,
  output logic signed [17:0] deriv_s,
  output logic signed [17:0] deriv_t,
  output logic               last_node,
  output logic               kind_error
);
  import fsfe_pkg::*;

  localparam int SQW  = 33;   // s*s range
  localparam int CUW  = 49;   // s*s*t range
  localparam int ACW  = 56;   // accumulator
  localparam int RW   = ACW - FRAC_BITS - 2;

  logic adv;
  assign adv = !out_stall || !out_valid;

  // ---- node sequencer
  logic        busy;
  logic [2:0]  node;
  logic [1:0]  kind;
  logic signed [15:0] s_h, t_h;
  logic [2:0]  last_idx;
  logic [2:0]  last_idx_next;

  always_comb begin
    case (element_kind)
      KIND_TRI3:  last_idx_next = 3'd2;
      KIND_QUAD4: last_idx_next = 3'd3;
      KIND_QUAD8: last_idx_next = 3'd7;
      default:    last_idx_next = 3'd0;
    endcase
  end

  // next input is taken while the last node issues
  assign in_stall = rst || !adv || (busy && (node != last_idx));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      node <= '0;
    end else if (adv) begin
      if (busy && (node != last_idx)) begin
        node <= node + 3'd1;
      end else if (in_valid) begin
        s_h <= s_coord; t_h <= t_coord; kind <= element_kind;
        last_idx <= last_idx_next;
        node <= '0;
        busy <= 1'b1;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  // ---- stage 1: squares and cross product
  logic v1; logic [2:0] n1; logic [1:0] k1; logic l1;
  logic signed [15:0] s1, t1;
  logic signed [SQW-1:0] ss1, st1, tt1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= busy;
    if (adv) begin
      n1 <= node; k1 <= kind; l1 <= (node == last_idx);
      s1 <= s_h; t1 <= t_h;
      ss1 <= SQW'(s_h * s_h); st1 <= SQW'(s_h * t_h); tt1 <= SQW'(t_h * t_h);
    end
  end

  // ---- stage 2: cubic terms
  logic v2; logic [2:0] n2; logic [1:0] k2; logic l2;
  logic signed [15:0] s2, t2;
  logic signed [SQW-1:0] ss2, st2, tt2;
  logic signed [CUW-1:0] sst2, stt2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      n2 <= n1; k2 <= k1; l2 <= l1; s2 <= s1; t2 <= t1;
      ss2 <= ss1; st2 <= st1; tt2 <= tt1;
      sst2 <= CUW'(ss1 * t1); stt2 <= CUW'(tt1 * s1);
    end
  end

  // ---- stage 3: coefficient sums
  // table coefficients are 0, +-1, +-2, +-4: select a shifted term
  function automatic logic signed [ACW-1:0] cmul(input coef_t c,
      input logic signed [ACW-1:0] x);
    case (c)
      4'sd1:   return x;
      -4'sd1:  return -x;
      4'sd2:   return x <<< 1;
      -4'sd2:  return -(x <<< 1);
      4'sd4:   return x <<< 2;
      -4'sd4:  return -(x <<< 2);
      default: return '0;
    endcase
  endfunction

  // quadratic part, at 2*FRAC_BITS fraction bits
  function automatic logic signed [ACW-1:0] poly_y(input coef_row_t c,
      input logic signed [15:0] s, input logic signed [15:0] t,
      input logic signed [SQW-1:0] ss, input logic signed [SQW-1:0] st,
      input logic signed [SQW-1:0] tt);
    logic signed [ACW-1:0] lin;
    lin = cmul(c[1], ACW'(s)) + cmul(c[2], ACW'(t)) + (ACW'(c[0]) <<< FRAC_BITS);
    return cmul(c[3], ACW'(ss)) + cmul(c[4], ACW'(st)) + cmul(c[5], ACW'(tt))
         + (lin <<< FRAC_BITS);
  endfunction

  // cubic part plus its rounding half, at 3*FRAC_BITS fraction bits
  function automatic logic signed [ACW-1:0] poly_d3h(input coef_row_t c,
      input logic signed [CUW-1:0] sst, input logic signed [CUW-1:0] stt);
    return cmul(c[6], ACW'(sst)) + cmul(c[7], ACW'(stt))
         + (ACW'(1) <<< (2 * FRAC_BITS + 1));
  endfunction

  logic signed [ACW-1:0] y_c [3];
  logic signed [ACW-1:0] dh_c [3];
  always_comb begin
    for (int q = 0; q < 3; q++) begin
      y_c[q]  = poly_y(coef_row(k2, n2, 2'(q)), s2, t2, ss2, st2, tt2);
      dh_c[q] = poly_d3h(coef_row(k2, n2, 2'(q)), sst2, stt2);
    end
  end

  logic v3; logic [2:0] n3; logic l3; logic e3;
  logic signed [ACW-1:0] y3 [3];
  logic signed [ACW-1:0] dh3 [3];
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      n3 <= n2; l3 <= l2; e3 <= (k2 == KIND_BAD);
      for (int q = 0; q < 3; q++) begin
        y3[q]  <= y_c[q];
        dh3[q] <= dh_c[q];
      end
    end
  end

  // ---- stage 4: rounding add, floor of w/4 at FRAC_BITS, saturate
  function automatic logic signed [17:0] sat18(input logic signed [ACW-1:0] y,
      input logic signed [ACW-1:0] dh);
    logic signed [ACW-1:0] w;
    logic signed [RW-1:0] r;
    w = y + (dh >>> FRAC_BITS);
    r = RW'(w >>> (FRAC_BITS + 2));
    if (r > RW'(131071)) return 18'sd131071;
    if (r < -RW'(131072)) return -18'sd131072;
    return r[17:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= v3;
    if (adv) begin
      node_index  <= n3;
      last_node   <= l3;
      kind_error  <= e3;
      shape_value <= e3 ? 18'sd0 : sat18(y3[0], dh3[0]);
      deriv_s     <= e3 ? 18'sd0 : sat18(y3[1], dh3[1]);
      deriv_t     <= e3 ? 18'sd0 : sat18(y3[2], dh3[2]);
    end
  end

endmodule
